// ===== sv/zzlc_pkg.sv =====
// Shared widths, codes and state encoding for the zigzag loss classifier.
package zzlc_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SEQ_W       = 32;
    localparam int AVG_W       = TIME_WIDTH + FRAC_BITS;
    localparam int DIFF_W      = AVG_W + 1;
    localparam int CMP_W       = AVG_W + 3;
    localparam int WEIGHT_FRAC = 16;
    localparam int CFG_W       = 16;
    localparam int WGT_W       = WEIGHT_FRAC + 1;
    localparam int MUL_LO_W    = 32;
    localparam int MUL_HI_W    = DIFF_W - MUL_LO_W;
    localparam int MUL_A_W     = MUL_LO_W + 1;
    localparam int MUL_B_W     = WGT_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SH_W        = MUL_LO_W - WEIGHT_FRAC;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [CFG_W-1:0]     AVG_WEIGHT_RESET = CFG_W'(2048);
    localparam logic [CFG_W-1:0]     WEIGHT_HALF      = CFG_W'(32768);
    localparam logic [WGT_W-1:0]     WEIGHT_ONE       = WGT_W'(65536);
    localparam logic [REG_IDX_W-1:0] REG_AVG_WEIGHT   = REG_IDX_W'(0);

    typedef enum logic [1:0] {
        LOSS_NONE       = 2'd0,
        LOSS_WIRELESS   = 2'd1,
        LOSS_CONGESTION = 2'd2
    } loss_class_t;

    typedef enum logic [1:0] {
        GAP_ZERO   = 2'd0,
        GAP_NARROW = 2'd1,
        GAP_WIDE   = 2'd2
    } gap_kind_t;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL_LO = 9'b000000010,
        ST_MUL_HI = 9'b000000100,
        ST_ACC    = 9'b000001000,
        ST_DIFF   = 9'b000010000,
        ST_ABS    = 9'b000100000,
        ST_SUB    = 9'b001000000,
        ST_THR    = 9'b010000000,
        ST_CMP    = 9'b100000000
    } state_t;

endpackage

// ===== sv/zigzag_loss_classifier.sv =====
// Zigzag loss classifier: running trip and deviation averages with a shared multiplier.
// First packet after reset: IDLE goes straight to CMP, skipping both average updates.
// Later packets: MUL_LO, MUL_HI, ACC, DIFF, ABS, SUB, MUL_LO, MUL_HI, ACC, THR, CMP.
// One 33x18 multiplier takes two passes per average; s_ready is high only in IDLE.
// A held result stalls the final compare step until it is taken.
// Reset (aresetn, synchronous, active low) clears history and sets the weight to 2048.
module zigzag_loss_classifier
    import zzlc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]          pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [SEQ_W-1:0]            s_seq_id,
    input  logic signed [TIME_WIDTH-1:0] s_trip_time,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_loss_class
);

    state_t                     state_reg, state_next;
    logic                       started_reg;
    logic                       m_valid_reg;
    loss_class_t                m_class_reg;
    logic [CFG_W-1:0]           alpha_reg;

    logic                       pass_reg;
    gap_kind_t                  gap_kind_reg;
    logic [SEQ_W-1:0]           last_seq_reg;
    logic signed [TIME_WIDTH-1:0] x_reg;
    logic [AVG_W-1:0]           trip_avg_reg;
    logic [AVG_W-1:0]           dev_avg_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic [AVG_W-1:0]           abs_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [AVG_W-1:0]           part_reg;
    logic signed [CMP_W-1:0]    thr_reg;

    logic                       in_req;
    logic                       out_load;
    logic                       cfg_wr;
    logic [REG_IDX_W-1:0]       reg_idx;
    logic [AVG_W-1:0]           xq_in;
    logic [AVG_W-1:0]           xq_held;
    logic signed [DIFF_W-1:0]   diff_in;
    logic signed [DIFF_W-1:0]   diff_held;
    logic signed [DIFF_W-1:0]   neg_diff;
    logic [SEQ_W-1:0]           gap;
    gap_kind_t                  gap_kind;
    logic [WGT_W-1:0]           avg_w;
    logic [WGT_W-1:0]           dev_w;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [AVG_W-1:0]           avg_sel;
    logic [AVG_W-1:0]           avg_new;
    logic [CMP_W-1:0]           dev_term;
    logic signed [CMP_W-1:0]    x_cmp;
    loss_class_t                cls;

    assign pready       = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_loss_class = m_class_reg;

    assign in_req   = s_valid & s_ready;
    assign out_load = (state_reg == ST_CMP) && (!m_valid_reg || m_ready);
    assign cfg_wr   = psel & penable & pwrite;
    assign reg_idx  = paddr[PADDR_W-1:2];

    always_comb begin
        unique case (reg_idx)
            REG_AVG_WEIGHT: prdata = PDATA_W'(alpha_reg);
            default:        prdata = '0;
        endcase
    end

    assign xq_in     = {s_trip_time, {FRAC_BITS{1'b0}}};
    assign xq_held   = {x_reg, {FRAC_BITS{1'b0}}};
    assign diff_in   = $signed({xq_in[AVG_W-1], xq_in})
                     - $signed({trip_avg_reg[AVG_W-1], trip_avg_reg});
    assign diff_held = $signed({xq_held[AVG_W-1], xq_held})
                     - $signed({trip_avg_reg[AVG_W-1], trip_avg_reg});
    assign neg_diff  = -diff_reg;

    assign gap = s_seq_id - last_seq_reg - SEQ_W'(1);

    always_comb begin
        if (!started_reg || gap == '0) begin
            gap_kind = GAP_ZERO;
        end else if (gap == SEQ_W'(1) || gap == SEQ_W'(3)) begin
            gap_kind = GAP_NARROW;
        end else begin
            gap_kind = GAP_WIDE;
        end
    end

    assign avg_w = {1'b0, alpha_reg};
    assign dev_w = (alpha_reg > WEIGHT_HALF) ? WEIGHT_ONE : {alpha_reg, 1'b0};

    assign mul_a = (state_reg == ST_MUL_LO)
                 ? $signed({1'b0, diff_reg[MUL_LO_W-1:0]})
                 : $signed({{(MUL_A_W-MUL_HI_W){diff_reg[DIFF_W-1]}},
                            diff_reg[DIFF_W-1:MUL_LO_W]});
    assign mul_b = $signed({1'b0, pass_reg ? dev_w : avg_w});
    assign mul_p = mul_a * mul_b;

    assign avg_sel = pass_reg ? dev_avg_reg : trip_avg_reg;
    assign avg_new = part_reg + {prod_reg[AVG_W-SH_W-1:0], {SH_W{1'b0}}};

    assign dev_term = (gap_kind_reg == GAP_NARROW)
                    ? {2'b00, dev_avg_reg, 1'b0}
                    : {3'b000, dev_avg_reg};
    assign x_cmp    = $signed({{2{x_reg[TIME_WIDTH-1]}}, x_reg, {(FRAC_BITS+1){1'b0}}});

    always_comb begin
        if (gap_kind_reg == GAP_ZERO) begin
            cls = LOSS_NONE;
        end else if (x_cmp < thr_reg) begin
            cls = LOSS_WIRELESS;
        end else begin
            cls = LOSS_CONGESTION;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    state_next = started_reg ? ST_MUL_LO : ST_CMP;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:    state_next = pass_reg ? ST_THR : ST_DIFF;
            ST_DIFF:   state_next = ST_ABS;
            ST_ABS:    state_next = ST_SUB;
            ST_SUB:    state_next = ST_MUL_LO;
            ST_THR:    state_next = ST_CMP;
            ST_CMP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            alpha_reg   <= AVG_WEIGHT_RESET;
        end else begin
            state_reg <= state_next;
            if (in_req) begin
                started_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr && reg_idx == REG_AVG_WEIGHT) begin
                alpha_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    x_reg        <= s_trip_time;
                    last_seq_reg <= s_seq_id;
                    gap_kind_reg <= gap_kind;
                    pass_reg     <= 1'b0;
                    diff_reg     <= diff_in;
                    if (!started_reg) begin
                        trip_avg_reg <= xq_in;
                        dev_avg_reg  <= '0;
                    end
                end
            end
            ST_MUL_LO: begin
                prod_reg <= mul_p;
            end
            ST_MUL_HI: begin
                part_reg <= avg_sel
                          + AVG_W'(prod_reg[MUL_LO_W+WGT_W-1:WEIGHT_FRAC]);
                prod_reg <= mul_p;
            end
            ST_ACC: begin
                if (pass_reg) begin
                    dev_avg_reg <= avg_new;
                end else begin
                    trip_avg_reg <= avg_new;
                end
            end
            ST_DIFF: begin
                diff_reg <= diff_held;
            end
            ST_ABS: begin
                abs_reg <= diff_reg[DIFF_W-1] ? neg_diff[AVG_W-1:0] : diff_reg[AVG_W-1:0];
            end
            ST_SUB: begin
                diff_reg <= $signed({1'b0, abs_reg}) - $signed({1'b0, dev_avg_reg});
                pass_reg <= 1'b1;
            end
            ST_THR: begin
                thr_reg <= $signed({{2{trip_avg_reg[AVG_W-1]}}, trip_avg_reg, 1'b0})
                         - $signed(dev_term);
            end
            ST_CMP: begin
                if (out_load) begin
                    m_class_reg <= cls;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_first_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_req && !started_reg) |=> (state_reg == ST_CMP && gap_kind_reg == GAP_ZERO))
        else $error("first packet did not go straight to classification");

    a_started_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |=> started_reg)
        else $error("history flag dropped without reset");

    a_dev_pass_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC && pass_reg) |=> (state_reg == ST_THR))
        else $error("deviation update not followed by threshold step");

    a_cmp_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP && m_valid_reg && !m_ready) |=> (state_reg == ST_CMP))
        else $error("classification left while result held");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        in_req |=> !s_ready)
        else $error("request taken while previous one in progress");
`endif

endmodule

// ===== tb/sv/tb_zigzag_loss_classifier.sv =====
// Testbench for the zigzag loss classifier: queue-fed request driver, result monitor and predictor.
module tb_zigzag_loss_classifier
    import zzlc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [SEQ_W-1:0]             seq;
        logic signed [TIME_WIDTH-1:0] trip;
    } packet_t;

    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_AVG_WEIGHT + 1'b1;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 30;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [PADDR_W-1:0]           paddr = '0;
    logic [PDATA_W-1:0]           pwdata = '0;
    logic [PDATA_W-1:0]           prdata;
    logic                         pready;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [SEQ_W-1:0]             s_seq_id = '0;
    logic signed [TIME_WIDTH-1:0] s_trip_time = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_loss_class;

    packet_t     packet_q[$];
    loss_class_t pending_classes[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    logic [SEQ_W-1:0] stream_seq;

    logic [CFG_W-1:0] avg_weight = AVG_WEIGHT_RESET;
    bit               started = 1'b0;
    logic [SEQ_W-1:0] last_seq = '0;
    wide_t            trip_avg = '0;
    wide_t            dev_avg = '0;

    zigzag_loss_classifier uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_seq_id(s_seq_id), .s_trip_time(s_trip_time),
        .m_valid(m_valid), .m_ready(m_ready), .m_loss_class(m_loss_class)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic flag_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic wide_t weigh_diff(wide_t d, logic [WGT_W-1:0] w);
        wide_t p;
        p = d * $signed({1'b0, w});
        return p >>> WEIGHT_FRAC;
    endfunction

    function automatic loss_class_t classify_packet(logic [SEQ_W-1:0] seq,
                                                    logic signed [TIME_WIDTH-1:0] trip);
        wide_t            xq;
        wide_t            dev_sample;
        logic [SEQ_W-1:0] gap;
        logic [WGT_W-1:0] dev_w;
        loss_class_t      cls;
        xq = trip;
        xq = xq <<< FRAC_BITS;
        dev_w = {avg_weight, 1'b0};
        if (dev_w > WEIGHT_ONE) begin
            dev_w = WEIGHT_ONE;
        end
        gap = '0;
        if (!started) begin
            trip_avg = xq;
            dev_avg = '0;
            started = 1'b1;
        end else begin
            trip_avg = trip_avg + weigh_diff(xq - trip_avg, {1'b0, avg_weight});
            dev_sample = xq - trip_avg;
            if (dev_sample < 0) begin
                dev_sample = -dev_sample;
            end
            dev_avg = dev_avg + weigh_diff(dev_sample - dev_avg, dev_w);
            gap = seq - last_seq - 1'b1;
        end
        last_seq = seq;
        if (gap == 0) begin
            cls = LOSS_NONE;
        end else if (gap == 1 || gap == 3) begin
            cls = (xq < trip_avg - dev_avg) ? LOSS_WIRELESS : LOSS_CONGESTION;
        end else begin
            cls = (2 * xq < 2 * trip_avg - dev_avg) ? LOSS_WIRELESS : LOSS_CONGESTION;
        end
        return cls;
    endfunction

    // request driver
    always @(posedge aclk) begin : drive_blk
        bit busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                pending_classes.push_back(classify_packet(s_seq_id, s_trip_time));
                void'(packet_q.pop_front());
                busy = 1'b0;
            end
            if (!busy) begin
                if (packet_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_seq_id <= packet_q[0].seq;
                    s_trip_time <= packet_q[0].trip;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin : check_blk
        loss_class_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_classes.size() == 0) begin
                flag_mismatch($sformatf("unexpected result class %0d", m_loss_class));
            end else begin
                want = pending_classes.pop_front();
                if (m_loss_class !== want) begin
                    flag_mismatch($sformatf("loss_class got %0d want %0d", m_loss_class, want));
                end
            end
        end
    end

    task automatic push_packet(logic [SEQ_W-1:0] seq, logic [TIME_WIDTH-1:0] trip);
        packet_t p;
        p.seq = seq;
        p.trip = trip;
        packet_q.push_back(p);
    endtask

    task automatic wait_drain();
        do @(negedge aclk);
        while (packet_q.size() != 0 || s_valid || pending_classes.size() != 0);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_AVG_WEIGHT) begin
            avg_weight = data[CFG_W-1:0];
        end
    endtask

    task automatic apb_check_weight();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {REG_AVG_WEIGHT, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        if (prdata !== PDATA_W'(avg_weight)) begin
            flag_mismatch($sformatf("weight read %0d want %0d", prdata, avg_weight));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_stream(int count);
        int               r;
        logic [31:0]      base;
        logic [31:0]      spread;
        logic [31:0]      trip;
        base = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 40000)) - 32'd20000;
        spread = 32'd1 << $urandom_range(0, 20);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) stream_seq = stream_seq + 1;
            else if (r < 65) stream_seq = stream_seq + 2;
            else if (r < 73) stream_seq = stream_seq + 3;
            else if (r < 81) stream_seq = stream_seq + 4;
            else if (r < 86) stream_seq = stream_seq + $urandom_range(5, 40);
            else if (r < 90) stream_seq = stream_seq;
            else if (r < 94) stream_seq = stream_seq - $urandom_range(1, 10);
            else stream_seq = $urandom;
            if ($urandom_range(0, 99) < 88) begin
                trip = base + $urandom_range(0, 2 * spread) - spread;
            end else begin
                trip = $urandom;
            end
            if ($urandom_range(0, 99) < 5) begin
                base = base + $urandom_range(0, 2 * spread) - spread;
            end
            push_packet(stream_seq, trip);
        end
    endtask

    initial begin : run_blk
        logic [CFG_W-1:0] weights[8];
        weights = '{16'd0, WEIGHT_HALF, 16'hFFFF, 16'd1, AVG_WEIGHT_RESET,
                    16'($urandom), 16'd40000, 16'd16384};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        apb_check_weight();

        push_packet(32'd0, 32'd0);
        push_packet(32'd1, 32'h7FFF_FFFF);
        push_packet(32'd3, 32'h8000_0000);
        push_packet(32'd7, 32'hFFFF_FFFF);
        push_packet(32'd10, 32'd100);
        push_packet(32'd10, 32'd0);
        push_packet(32'd5, -32'sd50);
        push_packet(32'd6, 32'h7FFF_FFFF);
        push_packet(32'd8, 32'h8000_0000);
        push_packet(32'hFFFF_FFFF, 32'd1000);
        push_packet(32'd0, 32'd1000);
        push_packet(32'd2, 32'd0);
        push_packet(32'd6, 32'd5000);
        push_packet(32'd7, 32'd10);
        push_packet(32'd9, -32'sd10);
        push_packet(32'd13, 32'd20);
        push_packet(32'hAAAA_AAAA, 32'h5555_5555);
        push_packet(32'h5555_5555, 32'hAAAA_AAAA);
        stream_seq = 32'h5555_5555;
        wait_drain();

        apb_write(REG_UNMAPPED, 32'd12345);
        apb_check_weight();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            apb_write(REG_AVG_WEIGHT, PDATA_W'(weights[p]));
            apb_check_weight();
            if (p % 4 == 0) begin
                hold_req = 1'b1;
            end
            queue_stream(35);
            wait_drain();
            queue_stream(34);
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/zzlc_pkg.sv
sv/zigzag_loss_classifier.sv
tb/sv/tb_zigzag_loss_classifier.sv
